[rtl/c2d_pkg.sv]
// Package: shared types and constants for the 2D convolution engine.
package c2d_pkg;

  localparam int MAX_ROWS   = 1024;
  localparam int MAX_COLS   = 1024;
  localparam int MAX_KERNEL = 7;
  localparam int PIXEL_BITS = 16;
  localparam int RES_BITS   = 37;
  localparam int CS_DEPTH   = MAX_KERNEL * MAX_KERNEL;
  localparam int LS_DEPTH   = MAX_KERNEL * MAX_COLS;
  localparam int CS_AW      = $clog2(CS_DEPTH);
  localparam int LS_AW      = $clog2(LS_DEPTH);
  localparam int DIM_BITS   = 11;
  localparam int KER_BITS   = 3;

  localparam logic [1:0] CMD_COEF   = 2'd0;
  localparam logic [1:0] CMD_PIXEL  = 2'd1;
  localparam logic [1:0] CMD_FLUSH  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [2:0] REG_MODE  = 3'd0;
  localparam logic [2:0] REG_ROWS  = 3'd1;
  localparam logic [2:0] REG_COLS  = 3'd2;
  localparam logic [2:0] REG_KROWS = 3'd3;
  localparam logic [2:0] REG_KCOLS = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE, ST_ADDR, ST_READ, ST_MUL, ST_ACC, ST_OUT
  } state_t;

  // Sequencer to datapath controls.
  typedef struct packed {
    logic clear;
    logic load;
    logic valid_tap;
  } mac_ctrl_t;

endpackage

[rtl/c2d_ram.sv]
// Generic single-port-write, one-read RAM with registered read data.
module c2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/c2d_mac.sv]
// Shared multiply-accumulate unit: one registered product, one accumulate a step.
module c2d_mac
  import c2d_pkg::*;
(
  input  logic                         clk,
  input  mac_ctrl_t                    ctrl,
  input  logic signed [PIXEL_BITS-1:0] pix,
  input  logic signed [PIXEL_BITS-1:0] coef,
  output logic signed [RES_BITS-1:0]   acc
);
  logic signed [2*PIXEL_BITS-1:0] prod_r;
  logic signed [RES_BITS-1:0]     acc_r;

  always_ff @(posedge clk) begin
    prod_r <= pix * coef;
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (ctrl.load && ctrl.valid_tap) begin
      acc_r <= acc_r + RES_BITS'(prod_r);
    end
  end

  assign acc = acc_r;
endmodule

[rtl/conv2d_stream_engine.sv]
// Top level of the streaming 2D convolution engine.
// A coefficient load, or a pixel or flush that completes no output, does not stall the input. A pixel
// or flush that completes an output stalls the input until its sum is moved to the output
// register: the single multiply-accumulate unit visits each kernel tap in turn, stepping
// through the ADDR, READ, MUL and ACC states on each to address the line and coefficient
// stores, read them, multiply and accumulate. New items are taken while the output register
// waits; a further result waits in the sequencer until the register is free.
module conv2d_stream_engine
  import c2d_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [DIM_BITS-1:0]          cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_cmd,
  input  logic [5:0]                   in_coef_index,
  input  logic signed [PIXEL_BITS-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [RES_BITS-1:0]   out_result,
  output logic [9:0]                   out_out_row,
  output logic [9:0]                   out_out_col,
  output logic                         out_last_of_frame
);
  logic              mode_r;
  logic [10:0]       rows_cfg_r, cols_cfg_r;
  logic [2:0]        kr_cfg_r, kc_cfg_r;
  logic [10:0]       R, C;
  logic [3:0]        KR, KC;
  logic [10:0]       in_row_r, in_row_nxt;
  logic [9:0]        in_col_r, in_col_nxt;
  logic [10:0]       nor_r, nor_nxt;
  logic [9:0]        noc_r, noc_nxt;
  logic [LS_AW-1:0]  wptr_r, wptr_nxt;
  logic [10:0]       orows, ocols;
  state_t            state_r, state_nxt;
  logic [2:0]        ki_r, ki_nxt, kj_r, kj_nxt;
  logic              tapv_r, tapv_d_r;
  logic              acc_go;
  logic [2:0]        cx, cy;
  logic              accept;
  logic              out_fire;
  logic              frame_done;
  logic              pend;
  mac_ctrl_t         mctrl;
  logic signed [RES_BITS-1:0] acc;
  logic signed [PIXEL_BITS-1:0] pix_q, coef_q;
  logic              ls_we, cs_we;
  logic [LS_AW-1:0]  ls_raddr, ls_raddr_r;
  logic [CS_AW-1:0]  cs_raddr_r;
  logic signed [12:0] tr, tc;
  logic [21:0]       rc_lin;
  logic [22:0]       received, needed;
  logic [10:0]       need_r, need_c;
  logic [11:0]       need_r_w, need_c_w;
  logic              last_r;

  // The line store holds seven lines of 1024, so a linear position wraps as
  // (position / 1024) mod 7 on top and the low ten bits below. Since 8 is 1 mod 7,
  // the mod 7 comes from summing the octal digits and folding.
  function automatic logic [LS_AW-1:0] ls_wrap(input logic [21:0] lin);
    logic [4:0] s1;
    logic [3:0] s2;
    logic [2:0] s3;
    s1 = 5'(lin[12:10]) + 5'(lin[15:13]) + 5'(lin[18:16]) + 5'(lin[21:19]);
    s2 = 4'(s1[2:0]) + 4'(s1[4:3]);
    s3 = s2[2:0] + 3'(s2[3]);
    if (s3 == 3'd7) s3 = 3'd0;
    return {s3, lin[9:0]};
  endfunction

  always_comb begin
    R  = (rows_cfg_r == 0) ? 11'd1 : ((rows_cfg_r > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) : rows_cfg_r);
    C  = (cols_cfg_r == 0) ? 11'd1 : ((cols_cfg_r > 11'(MAX_COLS)) ? 11'(MAX_COLS) : cols_cfg_r);
    KR = (kr_cfg_r == 0) ? 4'd1 : {1'b0, kr_cfg_r};
    KC = (kc_cfg_r == 0) ? 4'd1 : {1'b0, kc_cfg_r};
    cx = mode_r ? KR[3:1] : 3'd0;
    cy = mode_r ? KC[3:1] : 3'd0;
    if (mode_r) begin
      orows = R; ocols = C;
    end else if (R >= 11'(KR) && C >= 11'(KC)) begin
      orows = R - 11'(KR) + 11'd1; ocols = C - 11'(KC) + 11'd1;
    end else begin
      orows = '0; ocols = '0;
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_fire = (state_r == ST_OUT) && (!out_valid || !out_stall);

  // Input counters advance at acceptance; output decision uses the updated counts.
  always_comb begin
    in_row_nxt = in_row_r;
    in_col_nxt = in_col_r;
    wptr_nxt   = wptr_r;
    ls_we      = 1'b0;
    if (accept && in_cmd == CMD_PIXEL && in_row_r < R) begin
      ls_we = 1'b1;
      wptr_nxt = (wptr_r == LS_AW'(LS_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      if (11'(in_col_r) + 11'd1 >= C) begin
        in_col_nxt = '0;
        in_row_nxt = in_row_r + 11'd1;
      end else begin
        in_col_nxt = in_col_r + 10'd1;
      end
    end
  end

  assign cs_we = accept && in_cmd == CMD_COEF && in_coef_index < 6'(CS_DEPTH);

  always_comb begin
    need_r_w = 12'(nor_r) + 12'(KR) - 12'd1 - 12'(cx);
    need_c_w = 12'(noc_r) + 12'(KC) - 12'd1 - 12'(cy);
    need_r   = (need_r_w > 12'(R) - 12'd1) ? R - 11'd1 : need_r_w[10:0];
    need_c   = (need_c_w > 12'(C) - 12'd1) ? C - 11'd1 : need_c_w[10:0];
    received = 23'(in_row_nxt) * 23'(C) + 23'(in_col_nxt);
    needed   = 23'(need_r) * 23'(C) + 23'(need_c);
    pend     = nor_r < orows && 11'(noc_r) < ocols && received > needed;
  end

  // Tap address: the linear position wrapped to the line store depth, the same
  // sequence the write pointer steps through.
  always_comb begin
    tr = 13'(nor_r) + 13'(ki_r) - 13'(cx);
    tc = 13'(noc_r) + 13'(kj_r) - 13'(cy);
    rc_lin = 22'(tr[10:0]) * 22'(C) + 22'(tc[10:0]);
    ls_raddr = ls_wrap(rc_lin);
  end

  always_comb begin
    state_nxt = state_r;
    ki_nxt = ki_r;
    kj_nxt = kj_r;
    unique case (state_r)
      ST_IDLE: begin
        ki_nxt = '0; kj_nxt = '0;
        if (accept && (in_cmd == CMD_PIXEL || in_cmd == CMD_FLUSH) && pend) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: state_nxt = ST_READ;
      ST_READ: state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC: begin
        if (4'(kj_r) + 4'd1 < KC) begin
          kj_nxt = kj_r + 3'd1;
          state_nxt = ST_ADDR;
        end else if (4'(ki_r) + 4'd1 < KR) begin
          kj_nxt = '0;
          ki_nxt = ki_r + 3'd1;
          state_nxt = ST_ADDR;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      // The finished sum waits here until the output register is free.
      ST_OUT:  state_nxt = out_fire ? ST_IDLE : ST_OUT;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    mctrl.clear     = (state_r == ST_IDLE);
    mctrl.load      = acc_go;
    mctrl.valid_tap = tapv_d_r;
  end

  always_ff @(posedge clk) begin
    ls_raddr_r <= ls_raddr;
    cs_raddr_r <= CS_AW'(6'(KR - 4'd1 - 4'(ki_r)) * 6'(MAX_KERNEL) +
                         6'(KC - 4'd1 - 4'(kj_r)));
    tapv_r     <= tr >= 0 && tr < 13'(R) && tc >= 0 && tc < 13'(C);
    tapv_d_r   <= tapv_r;
    acc_go     <= (state_r == ST_MUL);
  end

  c2d_ram #(.WIDTH(PIXEL_BITS), .DEPTH(LS_DEPTH)) u_line (
    .clk(clk), .we(ls_we), .waddr(wptr_r), .wdata(in_value),
    .raddr(ls_raddr_r), .rdata(pix_q));

  c2d_ram #(.WIDTH(PIXEL_BITS), .DEPTH(CS_DEPTH)) u_coef (
    .clk(clk), .we(cs_we), .waddr(in_coef_index[CS_AW-1:0]), .wdata(in_value),
    .raddr(cs_raddr_r), .rdata(coef_q));

  c2d_mac u_mac (.clk(clk), .ctrl(mctrl), .pix(pix_q), .coef(coef_q), .acc(acc));

  always_comb begin
    nor_nxt = nor_r;
    noc_nxt = noc_r;
    if (out_fire) begin
      if (11'(noc_r) + 11'd1 >= ocols) begin
        noc_nxt = '0; nor_nxt = nor_r + 11'd1;
      end else begin
        noc_nxt = noc_r + 10'd1;
      end
    end
  end

  assign frame_done = in_row_nxt >= R && nor_nxt >= orows;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1; rows_cfg_r <= 11'd1024; cols_cfg_r <= 11'd1024;
      kr_cfg_r <= 3'd3; kc_cfg_r <= 3'd3;
      in_row_r <= '0; in_col_r <= '0; nor_r <= '0; noc_r <= '0; wptr_r <= '0;
      state_r <= ST_IDLE; ki_r <= '0; kj_r <= '0; out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt; ki_r <= ki_nxt; kj_r <= kj_nxt;
      out_valid <= out_fire || (out_valid && out_stall);
      if (cfg_we && cfg_index <= REG_KCOLS) begin
        unique case (cfg_index)
          REG_MODE:  mode_r <= cfg_data[0];
          REG_ROWS:  rows_cfg_r <= cfg_data;
          REG_COLS:  cols_cfg_r <= cfg_data;
          REG_KROWS: kr_cfg_r <= cfg_data[2:0];
          REG_KCOLS: kc_cfg_r <= cfg_data[2:0];
          default: ;
        endcase
        in_row_r <= '0; in_col_r <= '0; nor_r <= '0; noc_r <= '0; wptr_r <= '0;
      end else if ((accept && in_cmd == CMD_PIXEL) || out_fire ||
                   (accept && in_cmd == CMD_FLUSH)) begin
        if (frame_done && !(state_r == ST_IDLE && pend && accept)) begin
          in_row_r <= '0; in_col_r <= '0; nor_r <= '0; noc_r <= '0; wptr_r <= '0;
        end else begin
          in_row_r <= in_row_nxt; in_col_r <= in_col_nxt;
          nor_r <= nor_nxt; noc_r <= noc_nxt; wptr_r <= wptr_nxt;
        end
      end
    end
  end

  assign last_r = (nor_r == orows - 11'd1) && (11'(noc_r) == ocols - 11'd1);

  always_ff @(posedge clk) begin
    if (out_fire) begin
      out_result <= acc;
      out_out_row <= nor_r[9:0];
      out_out_col <= noc_r;
      out_last_of_frame <= last_r;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> in_stall) else $error("item accepted while busy");
  a_out_after_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == ST_OUT) else $error("stray result");
  a_cols_bound: assert property (@(posedge clk) disable iff (!rst_n)
    11'(in_col_r) < C || cfg_we || $past(cfg_we)) else $error("column counter overrun");
endmodule

[sim/testbench.sv]
// Self-checking testbench for the streaming 2D convolution engine.
`timescale 1ns / 100ps

class conv_scoreboard;
  // Expected result fields, oldest first.
  logic signed [36:0] exp_sum[$];
  logic [9:0] exp_row[$];
  logic [9:0] exp_col[$];
  logic exp_last[$];
  int errors;

  // Predictor state.
  logic signed [15:0] coefs[49];
  logic signed [15:0] lines[7168];
  int in_r, in_c, nxt_r, nxt_c;
  bit padded;
  int rows_reg, cols_reg, krows_reg, kcols_reg;

  function new();
    errors = 0;
    padded = 1; rows_reg = 1024; cols_reg = 1024; krows_reg = 3; kcols_reg = 3;
    restart();
  endfunction

  function void restart();
    in_r = 0; in_c = 0; nxt_r = 0; nxt_c = 0;
  endfunction

  function int clampi(int v, int lo, int hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function void write_reg(logic [2:0] idx, logic [10:0] data);
    case (idx)
      c2d_pkg::REG_MODE:  padded = data[0];
      c2d_pkg::REG_ROWS:  rows_reg = data;
      c2d_pkg::REG_COLS:  cols_reg = data;
      c2d_pkg::REG_KROWS: krows_reg = data[2:0];
      c2d_pkg::REG_KCOLS: kcols_reg = data[2:0];
      default: return;
    endcase
    restart();
  endfunction

  function void note_item(logic [1:0] cmd, logic [5:0] cidx, logic signed [15:0] val);
    int nr, nc, kr, kc, orows, ocols, cx, cy, need_r, need_c, rcv, r, c;
    longint acc;
    nr = clampi(rows_reg, 1, 1024);
    nc = clampi(cols_reg, 1, 1024);
    kr = clampi(krows_reg, 1, 7);
    kc = clampi(kcols_reg, 1, 7);
    if (cmd == c2d_pkg::CMD_COEF) begin
      if (cidx < 49) coefs[cidx] = val;
      return;
    end
    if (cmd != c2d_pkg::CMD_PIXEL && cmd != c2d_pkg::CMD_FLUSH) return;
    if (cmd == c2d_pkg::CMD_PIXEL && in_r < nr) begin
      lines[(in_r * nc + in_c) % 7168] = val;
      in_c++;
      if (in_c >= nc) begin
        in_c = 0;
        in_r++;
      end
    end
    if (padded) begin
      orows = nr; ocols = nc;
    end else if (nr >= kr && nc >= kc) begin
      orows = nr - kr + 1; ocols = nc - kc + 1;
    end else begin
      orows = 0; ocols = 0;
    end
    rcv = in_r * nc + in_c;
    if (nxt_r < orows && nxt_c < ocols) begin
      cx = padded ? kr / 2 : 0;
      cy = padded ? kc / 2 : 0;
      need_r = nxt_r + kr - 1 - cx;
      need_c = nxt_c + kc - 1 - cy;
      if (need_r > nr - 1) need_r = nr - 1;
      if (need_c > nc - 1) need_c = nc - 1;
      if (rcv > need_r * nc + need_c) begin
        acc = 0;
        for (int ki = 0; ki < kr; ki++)
          for (int kj = 0; kj < kc; kj++) begin
            r = nxt_r + ki - cx;
            c = nxt_c + kj - cy;
            if (r >= 0 && r < nr && c >= 0 && c < nc)
              acc += longint'(lines[(r * nc + c) % 7168]) *
                     longint'(coefs[(kr - 1 - ki) * 7 + (kc - 1 - kj)]);
          end
        exp_sum.push_back(acc[36:0]);
        exp_row.push_back(nxt_r[9:0]);
        exp_col.push_back(nxt_c[9:0]);
        exp_last.push_back(nxt_r == orows - 1 && nxt_c == ocols - 1);
        nxt_c++;
        if (nxt_c >= ocols) begin
          nxt_c = 0;
          nxt_r++;
        end
      end
    end
    if (in_r >= nr && nxt_r >= orows) restart();
  endfunction

  function void check_result(logic signed [36:0] sum, logic [9:0] row, logic [9:0] col,
                             logic last);
    logic signed [36:0] es;
    logic [9:0] er, ec;
    logic el;
    if (exp_sum.size() == 0) begin
      $display("%0t: unexpected result sum=%0d row=%0d col=%0d", $time, sum, row, col);
      errors++;
      return;
    end
    es = exp_sum.pop_front();
    er = exp_row.pop_front();
    ec = exp_col.pop_front();
    el = exp_last.pop_front();
    if (sum !== es) begin
      $display("%0t: result mismatch expected %0d actual %0d", $time, es, sum);
      errors++;
    end
    if (row !== er) begin
      $display("%0t: out_row mismatch expected %0d actual %0d", $time, er, row);
      errors++;
    end
    if (col !== ec) begin
      $display("%0t: out_col mismatch expected %0d actual %0d", $time, ec, col);
      errors++;
    end
    if (last !== el) begin
      $display("%0t: last_of_frame mismatch expected %0d actual %0d", $time, el, last);
      errors++;
    end
  endfunction

  function int pending();
    return exp_sum.size();
  endfunction
endclass

module testbench;
  import c2d_pkg::*;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [DIM_BITS-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [1:0] in_cmd = '0;
  logic [5:0] in_coef_index = '0;
  logic signed [PIXEL_BITS-1:0] in_value = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [RES_BITS-1:0] out_result;
  logic [9:0] out_out_row, out_out_col;
  logic out_last_of_frame;

  conv_scoreboard board;
  int cycles = 0;
  bit hold_req = 0;
  bit hold_busy = 0;
  // Frame shape currently configured, for building stimulus.
  int cur_rows, cur_cols;

  conv2d_stream_engine uut (.*);

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 6000000) begin
      $display("testbench failed");
      $finish;
    end
  end

  // Result checking on the rising edge.
  always @(posedge clk)
    if (rst_n && out_valid && !out_stall)
      board.check_result(out_result, out_out_row, out_out_col, out_last_of_frame);

  // Receiver stall: random gaps, plus one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_busy = 1;
        out_stall <= 1;
        repeat (3000) @(negedge clk);
        out_stall <= 0;
        hold_req = 0;
        hold_busy = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 4);
        out_stall <= 1;
        repeat (n) @(negedge clk);
        out_stall <= 0;
      end else if ($urandom_range(0, 99) == 0) begin
        repeat ($urandom_range(50, 200)) @(negedge clk);
      end
    end
  end

  // Leaves in_valid high on return; the next gap or the caller drops it.
  task automatic send_item(logic [1:0] cmd, logic [5:0] idx, logic signed [15:0] val,
                           bit gaps = 1);
    int n;
    if (gaps && $urandom_range(0, 3) == 0) begin
      n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 300) : $urandom_range(1, 3);
      in_valid <= 0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1;
    in_cmd <= cmd;
    in_coef_index <= idx;
    in_value <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_item(cmd, idx, val);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 0;
    while (board.pending() != 0) @(negedge clk);
    // A flush or pixel with no result may still be in progress.
    repeat (250) @(negedge clk);
  endtask

  task automatic write_cfg(logic [2:0] idx, logic [10:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    board.write_reg(idx, data);
  endtask

  task automatic setup(bit mode, int rows, int cols, int kr, int kc);
    wait_drain();
    write_cfg(REG_MODE, 11'(mode));
    write_cfg(REG_ROWS, 11'(rows));
    write_cfg(REG_COLS, 11'(cols));
    write_cfg(REG_KROWS, 11'(kr));
    write_cfg(REG_KCOLS, 11'(kc));
    cfg_we <= 0;
    cur_rows = board.clampi(rows, 1, 1024);
    cur_cols = board.clampi(cols, 1, 1024);
  endtask

  function automatic logic signed [15:0] rand_val();
    case ($urandom_range(0, 5))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return $signed(16'($urandom_range(0, 7))) - 16'sd3;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic load_kernel();
    for (int i = 0; i < 49; i++) send_item(CMD_COEF, i[5:0], rand_val());
  endtask

  // One full frame of pixels, then flushes and pixels enough to bring all outputs out.
  task automatic run_frame(int extra);
    for (int p = 0; p < cur_rows * cur_cols; p++) begin
      if ($urandom_range(0, 19) == 0) send_item(CMD_UNUSED, 6'($urandom), 16'($urandom));
      send_item(CMD_PIXEL, 6'($urandom), rand_val());
    end
    for (int f = 0; f < cur_rows * cur_cols + extra; f++)
      send_item($urandom_range(0, 3) == 0 ? CMD_PIXEL : CMD_FLUSH, 6'($urandom), rand_val());
  endtask

  // The start of a frame only; the next configuration write restarts it.
  task automatic run_partial(int npix, int nflush);
    for (int p = 0; p < npix; p++) send_item(CMD_PIXEL, 6'($urandom), rand_val());
    for (int f = 0; f < nflush; f++) send_item(CMD_FLUSH, 6'($urandom), rand_val());
  endtask

  initial begin
    int frames;
    board = new();
    repeat (11) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    // Directed: coefficient extremes, out-of-range index, unused command.
    setup(1, 2, 3, 3, 3);
    load_kernel();
    send_item(CMD_COEF, 6'd63, 16'sh7fff);
    send_item(CMD_COEF, 6'd49, 16'sh8000);
    send_item(CMD_UNUSED, 6'd0, 16'sh1234);
    send_item(CMD_FLUSH, 6'd0, 16'sd0);
    for (int p = 0; p < 6; p++) send_item(CMD_PIXEL, 6'd0, p[0] ? 16'sh8000 : 16'sh7fff);
    for (int f = 0; f < 8; f++) send_item(CMD_FLUSH, 6'd0, 16'sd0);

    // Valid mode with a kernel larger than the image: no outputs.
    setup(0, 2, 2, 3, 3);
    run_frame(2);
    // Out-of-range sizes saturate.
    setup(0, 0, 0, 0, 0);
    run_frame(2);
    setup(1, 1, 1, 7, 7);
    run_frame(2);
    setup(0, 7, 7, 7, 7);
    load_kernel();
    run_frame(2);

    // Back pressure: long receiver hold-off while items keep coming.
    setup(1, 4, 5, 3, 3);
    hold_req = 1;
    @(negedge clk);
    run_frame(3);
    in_valid <= 0;
    while (hold_busy || hold_req) @(negedge clk);
    wait_drain();
    // The start of a frame at the widest line.
    setup(1, 2, 1024, 1, 2);
    run_partial(300, 4);

    // Random frames with small sizes.
    frames = 0;
    while (frames < 20) begin
      setup($urandom_range(0, 1), $urandom_range(1, 6), $urandom_range(1, 6),
            $urandom_range(1, 7), $urandom_range(1, 7));
      if ($urandom_range(0, 2) == 0) load_kernel();
      else repeat ($urandom_range(1, 5)) send_item(CMD_COEF, 6'($urandom_range(0, 63)), rand_val());
      run_frame($urandom_range(0, 3));
      frames++;
    end
    // Extremes of the register fields, never reset values only.
    setup(1, 11'h7ff, 3, 7, 1);
    run_partial(40, 4);

    wait_drain();
    if (board.errors == 0 && board.pending() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule

[sim.f]
rtl/c2d_pkg.sv
rtl/c2d_ram.sv
rtl/c2d_mac.sv
rtl/conv2d_stream_engine.sv
sim/testbench.sv
